>>> sv/vre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vre_pkg
// Shared constants, types and state encoding for the value rank engine.
// ----------------------------------------------------------------------------
package vre_pkg;

  localparam int MaxElements = 64;
  localparam int AddrW       = $clog2(MaxElements);
  localparam int CntW        = $clog2(MaxElements + 1);
  localparam int ValueW      = 32;
  localparam int PosW        = 6;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_PIVOT,
    S_LOAD,
    S_SWEEP,
    S_EMIT
  } state_e;

  // control from the sequencer to the shared compare/count unit
  typedef struct packed {
    logic load_pivot;
    logic clear;
    logic step;
  } rank_ctl_t;

endpackage

>>> sv/vre_value_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vre_value_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vre_value_mem (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [vre_pkg::AddrW-1:0]  wr_addr_i,
  input  logic [vre_pkg::ValueW-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [vre_pkg::AddrW-1:0]  rd_addr_i,
  output logic [vre_pkg::ValueW-1:0] rd_data_o
);

  logic [vre_pkg::ValueW-1:0] mem [vre_pkg::MaxElements];
  logic [vre_pkg::ValueW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/vre_rank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vre_rank_unit
// Shared signed comparator and counter: holds the pivot and counts the
// swept elements that are strictly smaller than it.
// ----------------------------------------------------------------------------
module vre_rank_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vre_pkg::rank_ctl_t         ctl_i,
  input  logic [vre_pkg::ValueW-1:0] data_i,
  output logic [vre_pkg::AddrW-1:0]  rank_o
);

  logic [vre_pkg::ValueW-1:0] pivot_q;
  logic [vre_pkg::AddrW-1:0]  rank_q, rank_d;
  logic                       less;

  assign less = $signed(data_i) < $signed(pivot_q);

  always_comb begin
    rank_d = rank_q;
    if (ctl_i.clear) begin
      rank_d = '0;
    end else if (ctl_i.step && less) begin
      rank_d = rank_q + vre_pkg::AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_pivot) begin
      pivot_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else begin
      rank_q <= rank_d;
    end
  end

  assign rank_o = rank_q;

endmodule

>>> sv/value_rank_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_rank_engine
// Ranks a set of signed values: each result is the count of stored elements
// strictly smaller than the element, given in input order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one element per beat; last_item_i
//   ends the set. Elements beyond MaxElements are dropped and every result of
//   that set carries overflowed_o = 1; the last item still ends the set.
//   Output channel (out_valid_o/out_ready_i): one beat per stored element,
//   position_o in input order, last_result_o on the final one.
//   Elements are taken one per cycle while collecting. After the last item
//   the input is held off while ranks are computed: each element takes a
//   pivot read, a pivot load, one compare per stored element through the
//   single memory read port and shared comparator, and an emit step.
//   Results sit in an output register; a stalled receiver holds the
//   sequencer in the emit step. Input is accepted again as soon as the final
//   result is loaded, even while it still waits to be taken.
//   Reset empties the set and clears the overflow flag; the store itself is
//   not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module value_rank_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [vre_pkg::ValueW-1:0] value_i,
  input  logic                      last_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [vre_pkg::PosW-1:0]   position_o,
  output logic [vre_pkg::PosW-1:0]   rank_o,
  output logic                      overflowed_o,
  output logic                      last_result_o
);

  vre_pkg::state_e state_q, state_d;

  logic [vre_pkg::CntW-1:0]  count_q, count_d;
  logic [vre_pkg::CntW-1:0]  i_q, i_d;
  logic [vre_pkg::CntW-1:0]  j_q, j_d;
  logic                      ovf_q, ovf_d;

  logic                      out_valid_q, out_valid_d;
  logic [vre_pkg::PosW-1:0]  position_q, rank_q;
  logic                      overflowed_q, last_result_q;

  logic                      in_beat;
  logic                      full;
  logic                      out_free;
  logic                      is_last_elem;
  logic                      emit;
  logic                      rd_en;
  logic [vre_pkg::AddrW-1:0] rd_addr;
  logic [vre_pkg::ValueW-1:0] rd_data;
  vre_pkg::rank_ctl_t        ctl;
  logic [vre_pkg::AddrW-1:0] unit_rank;

  assign in_ready_o   = (state_q == vre_pkg::S_COLLECT);
  assign in_beat      = in_valid_i && in_ready_o;
  assign full         = (count_q == vre_pkg::CntW'(vre_pkg::MaxElements));
  assign out_free     = !out_valid_q || out_ready_i;
  assign is_last_elem = ((i_q + vre_pkg::CntW'(1)) == count_q);

  vre_value_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_beat && !full),
    .wr_addr_i (count_q[vre_pkg::AddrW-1:0]),
    .wr_data_i (value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  vre_rank_unit u_rank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .data_i (rd_data),
    .rank_o (unit_rank)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vre_pkg::S_COLLECT: if (in_beat && last_item_i) state_d = vre_pkg::S_PIVOT;
      vre_pkg::S_PIVOT:   state_d = vre_pkg::S_LOAD;
      vre_pkg::S_LOAD:    state_d = vre_pkg::S_SWEEP;
      vre_pkg::S_SWEEP:   if (j_q == count_q) state_d = vre_pkg::S_EMIT;
      vre_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = is_last_elem ? vre_pkg::S_COLLECT : vre_pkg::S_PIVOT;
        end
      end
      default:            state_d = vre_pkg::S_COLLECT;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd_en          = 1'b0;
    rd_addr        = '0;
    ctl            = '0;
    emit           = 1'b0;
    unique case (state_q)
      vre_pkg::S_COLLECT: ;
      vre_pkg::S_PIVOT: begin
        rd_en   = 1'b1;
        rd_addr = i_q[vre_pkg::AddrW-1:0];
      end
      vre_pkg::S_LOAD: begin
        // pivot arrives; start the sweep at element 0
        ctl.load_pivot = 1'b1;
        ctl.clear      = 1'b1;
        rd_en          = 1'b1;
        rd_addr        = '0;
      end
      vre_pkg::S_SWEEP: begin
        ctl.step = 1'b1;
        rd_en    = (j_q != count_q);
        rd_addr  = j_q[vre_pkg::AddrW-1:0];
      end
      vre_pkg::S_EMIT:    emit = out_free;
      default: ;
    endcase
  end

  // counters, flags and output register
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_beat) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + vre_pkg::CntW'(1);
      end
      i_d = '0;
    end
    if (state_q == vre_pkg::S_LOAD) begin
      j_d = vre_pkg::CntW'(1);
    end else if (state_q == vre_pkg::S_SWEEP && j_q != count_q) begin
      j_d = j_q + vre_pkg::CntW'(1);
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (is_last_elem) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        i_d = i_q + vre_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vre_pkg::S_COLLECT;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      position_q    <= vre_pkg::PosW'(i_q);
      rank_q        <= vre_pkg::PosW'(unit_rank);
      overflowed_q  <= ovf_q;
      last_result_q <= is_last_elem;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign position_o    = position_q;
  assign rank_o        = rank_q;
  assign overflowed_o  = overflowed_q;
  assign last_result_o = last_result_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vre_pkg::CntW'(vre_pkg::MaxElements))
    else $error("element count beyond capacity");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flag set while store not full");

  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != vre_pkg::S_COLLECT) |-> (count_q != '0 && i_q < count_q))
    else $error("ranking with an empty set or index out of range");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vre_pkg::S_SWEEP) |-> (vre_pkg::CntW'(unit_rank) < j_q))
    else $error("rank exceeds number of compared elements");
`endif

endmodule

>>> verif/value_rank_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_rank_engine_test
// Self-checking bench for the value rank engine. Sets of signed values go in
// through the input channel. A model of the block ranks each set once its
// last element is taken and queues the expected beats. A checker compares
// every output beat against that queue. Both sides idle and stall at random,
// and full and overflowing sets are covered.
// ----------------------------------------------------------------------------
module value_rank_engine_test;

  localparam int HoldCycles = 1500;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [vre_pkg::PosW-1:0] pos;
    logic [vre_pkg::PosW-1:0] rnk;
    logic                     ovf;
    logic                     fin;
  } rank_entry_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [vre_pkg::ValueW-1:0] value;
  logic                       last_item;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [vre_pkg::PosW-1:0]   position;
  logic [vre_pkg::PosW-1:0]   rank;
  logic                       overflowed;
  logic                       last_result;

  // model of the set being collected
  logic [vre_pkg::ValueW-1:0] held_vals [vre_pkg::MaxElements];
  int                held_count = 0;
  bit                held_ovf = 1'b0;
  rank_entry_t       expected_ranks [$];

  int       error_count = 0;
  int       items_sent = 0;
  int       sets_sent = 0;
  int       overflow_sets = 0;
  int       results_checked = 0;
  bit       tx_gaps = 1'b0;
  int       burst_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int       hold_req = 0;
  int       hold_ack = 0;
  int       hold_left = 0;
  int       rx_cycle = 0;

  value_rank_engine dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .value_i      (value),
    .last_item_i  (last_item),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .position_o   (position),
    .rank_o       (rank),
    .overflowed_o (overflowed),
    .last_result_o(last_result)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= 40) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    end
  endtask

  // Take one accepted element; on the last one rank the whole set.
  task automatic absorb_element(input logic [vre_pkg::ValueW-1:0] v, input logic lst);
    rank_entry_t e;
    int          cnt;
    if (held_count < vre_pkg::MaxElements) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (lst) begin
      for (int i = 0; i < held_count; i++) begin
        cnt = 0;
        for (int j = 0; j < held_count; j++) begin
          if ($signed(held_vals[j]) < $signed(held_vals[i])) cnt++;
        end
        e.pos = i[vre_pkg::PosW-1:0];
        e.rnk = cnt[vre_pkg::PosW-1:0];
        e.ovf = held_ovf;
        e.fin = (i == held_count - 1);
        expected_ranks.push_back(e);
      end
      sets_sent++;
      if (held_ovf) overflow_sets++;
      held_count = 0;
      held_ovf = 1'b0;
    end
  endtask

  task automatic send_item(input logic [vre_pkg::ValueW-1:0] v, input logic lst);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    value     <= v;
    last_item <= lst;
    do @(posedge clk); while (!in_ready);
    absorb_element(v, lst);
    items_sent++;
    // bursts with random gaps; payload is scrambled while valid is low
    if (tx_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 7);
        burst_left = $urandom_range(1, 10);
        @(negedge clk);
        in_valid  <= 1'b0;
        value     <= $urandom;
        last_item <= 1'($urandom_range(0, 1));
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // sender goes idle so the last beat is not offered twice
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk);
  endtask

  function automatic logic [vre_pkg::ValueW-1:0] rand_value();
    logic [vre_pkg::ValueW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $urandom_range(0, 8) - 4;    // small pool, many ties
      7:          v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default:    v = ($urandom_range(0, 1) ? 32'h7fff_fff0 : 32'h8000_0000)
                      + $urandom_range(0, 15);
    endcase
    return v;
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_item(rand_value(), i == n - 1);
  endtask

  task automatic test_directed();
    tx_gaps = 1'b0;
    rx_mode = RX_OPEN;
    send_item(32'd0, 1'b1);                 // single element
    send_item(32'h7fff_ffff, 1'b0);         // extremes, sign boundary, dups
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h8000_0001, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b1);
    for (int i = 0; i < 4; i++) send_item(32'd5, i == 3);   // all equal
    for (int i = 3; i >= 0; i--) send_item(i, i == 0);       // descending
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_sets();
    int stop_at;
    int r;
    stop_at = items_sent + 50;
    while (items_sent < stop_at) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      tx_gaps = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 9);
      if (r < 6) send_set($urandom_range(1, 6));
      else if (r < 9) send_set($urandom_range(7, 16));
      else send_set($urandom_range(17, 32));
      if ($urandom_range(0, 3) == 0) wait_drain();
    end
    wait_drain();
  endtask

  // Receiver held off while the sender keeps offering: the block backs up.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_mode = RX_LIGHT;
    hold_req++;
    send_set(4);
    send_set(3);
    send_set(5);
    wait_drain();
  endtask

  // fills the store and keeps going past it
  task automatic test_capacity();
    rx_mode = RX_HEAVY;
    tx_gaps = 1'b1;
    send_set(vre_pkg::MaxElements + $urandom_range(1, 4));
    wait_drain();
  endtask

  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = HoldCycles;
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= $urandom_range(0, 3) != 0;
        RX_HEAVY: out_ready <= $urandom_range(0, 3) == 0;
        default:  out_ready <= (rx_cycle % 8) < 5;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    rank_entry_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ranks.size() == 0) begin
        report_mismatch("unexpected beat, position", position, -1);
      end else begin
        want = expected_ranks.pop_front();
        results_checked++;
        if (position !== want.pos) report_mismatch("position", position, want.pos);
        if (rank !== want.rnk) report_mismatch("rank", rank, want.rnk);
        if (overflowed !== want.ovf) report_mismatch("overflowed", overflowed, want.ovf);
        if (last_result !== want.fin) report_mismatch("last_result", last_result, want.fin);
      end
    end
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    value     = '0;
    last_item = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_sets();
    test_backpressure();
    test_capacity();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drain();
    repeat (200) @(posedge clk);
    if (expected_ranks.size() != 0) begin
      report_mismatch("beats never delivered", 0, expected_ranks.size());
    end

    $display("Covered %0d elements in %0d sets, %0d of them over capacity.",
             items_sent, sets_sent, overflow_sets);
    $display("Checked %0d rank beats under random gaps, stalls and a long hold-off.",
             results_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/vre_pkg.sv
sv/vre_value_mem.sv
sv/vre_rank_unit.sv
sv/value_rank_engine.sv
verif/value_rank_engine_test.sv
